### rtl/tcm_pkg.sv
package tcm_pkg;

    // ring and field geometry
    localparam int DEPTH      = 16;
    localparam int PTR_W      = $clog2(DEPTH);
    localparam int FILL_W     = PTR_W + 1;
    localparam int TIME_W     = 48;
    localparam int IDX_W      = 32;
    localparam int VAL_W      = 16;
    localparam int WIN_W      = 16;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;

    // window reset values
    localparam logic [WIN_W-1:0] WINDOW_BEFORE_RST = WIN_W'(200);
    localparam logic [WIN_W-1:0] WINDOW_AFTER_RST  = WIN_W'(200);

    // event sources
    typedef logic [1:0] t_func;
    localparam t_func FUNC_PRIMARY = 2'd0;
    localparam t_func FUNC_SEC_A   = 2'd1;
    localparam t_func FUNC_SEC_B   = 2'd2;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_BEFORE = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_AFTER  = 1'b1;

    // ring select
    localparam logic RING_A = 1'b0;
    localparam logic RING_B = 1'b1;

    typedef struct packed {
        t_func              func;
        logic [TIME_W-1:0]  stamp;
        logic [VAL_W-1:0]   check_value;
    } t_in;

    typedef struct packed {
        logic [IDX_W-1:0]   primary_index;
        logic [IDX_W-1:0]   index_a;
        logic [IDX_W-1:0]   index_b;
        logic [TIME_W-1:0]  stamp_primary;
        logic [TIME_W-1:0]  stamp_a;
        logic [TIME_W-1:0]  stamp_b;
        logic [VAL_W-1:0]   value_primary;
        logic [VAL_W-1:0]   value_a;
        logic [VAL_W-1:0]   value_b;
    } t_out;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PRUNE,
        ST_FIND,
        ST_EMIT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic accept;     // input request taken this cycle
        logic sel;        // ring under walk
        logic pop;        // drop oldest entry of selected ring
        logic scan_inc;   // step search to next entry
        logic scan_clr;   // restart at oldest entry
        logic take;       // latch current entry as the match
        logic miss;       // selected ring has no match
        logic emit;       // load the result register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic in_primary;
        logic fill_zero;
        logic lower_ok;
        logic in_window;
        logic scan_end;
        logic found_a;
        logic out_free;
    } t_sts;

endpackage

### rtl/tcm_datapath.sv
module tcm_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tcm_pkg::t_in                      i_in,
    input  logic                              i_cfg_we,
    input  logic [tcm_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [tcm_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  tcm_pkg::t_cmd                     i_cmd,
    output tcm_pkg::t_sts                     o_sts,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output tcm_pkg::t_out                     o_out
);

    localparam int TW = tcm_pkg::TIME_W;

    // window registers
    logic [tcm_pkg::WIN_W-1:0] r_wb;
    logic [tcm_pkg::WIN_W-1:0] r_wa;

    // sequence counters
    logic [tcm_pkg::IDX_W-1:0] r_cnt_p;
    logic [tcm_pkg::IDX_W-1:0] r_cnt [2];

    // ring pointers
    logic [tcm_pkg::PTR_W-1:0]  r_head [2];
    logic [tcm_pkg::FILL_W-1:0] r_fill [2];

    // ring contents
    logic [TW-1:0]              r_time [2][tcm_pkg::DEPTH];
    logic [tcm_pkg::VAL_W-1:0]  r_val  [2][tcm_pkg::DEPTH];
    logic [tcm_pkg::IDX_W-1:0]  r_idx  [2][tcm_pkg::DEPTH];

    // search offset from head
    logic [tcm_pkg::FILL_W-1:0] r_k;

    // current primary
    logic [TW-1:0]              r_p_stamp;
    logic [tcm_pkg::VAL_W-1:0]  r_p_val;
    logic [tcm_pkg::IDX_W-1:0]  r_p_idx;

    // matches
    logic                       r_found_a;
    logic [TW-1:0]              r_m_time [2];
    logic [tcm_pkg::VAL_W-1:0]  r_m_val  [2];
    logic [tcm_pkg::IDX_W-1:0]  r_m_idx  [2];

    // result register
    logic                       r_out_valid;
    tcm_pkg::t_out              r_out;

    logic [tcm_pkg::PTR_W-1:0]  head_s;
    logic [tcm_pkg::FILL_W-1:0] fill_s;
    logic [tcm_pkg::PTR_W-1:0]  rd_pos;
    logic [TW-1:0]              rd_time;
    logic [TW:0]                low_sum;
    logic [TW:0]                up_sum;
    logic                       lower_ok;
    logic                       upper_ok;
    logic                       push_en;
    logic                       push_ring;
    logic [tcm_pkg::PTR_W-1:0]  wr_pos;
    logic                       push_full;
    logic                       out_free;

    // read port: oldest entry plus search offset
    assign head_s  = r_head[i_cmd.sel];
    assign fill_s  = r_fill[i_cmd.sel];
    assign rd_pos  = head_s + r_k[tcm_pkg::PTR_W-1:0];
    assign rd_time = r_time[i_cmd.sel][rd_pos];

    // window bounds in one extra bit so they never wrap
    assign low_sum  = {1'b0, rd_time} + (TW+1)'(r_wb);
    assign up_sum   = {1'b0, r_p_stamp} + (TW+1)'(r_wa);
    assign lower_ok = low_sum > {1'b0, r_p_stamp};
    assign upper_ok = {1'b0, rd_time} < up_sum;

    // write port for secondary events
    assign push_en   = i_cmd.accept &&
                       (i_in.func == tcm_pkg::FUNC_SEC_A || i_in.func == tcm_pkg::FUNC_SEC_B);
    assign push_ring = (i_in.func == tcm_pkg::FUNC_SEC_B) ? tcm_pkg::RING_B : tcm_pkg::RING_A;
    assign push_full = r_fill[push_ring] == tcm_pkg::FILL_W'(tcm_pkg::DEPTH);
    assign wr_pos    = r_head[push_ring] + r_fill[push_ring][tcm_pkg::PTR_W-1:0];

    assign out_free = !r_out_valid || i_out_ready;

    // status to controller
    always_comb begin
        o_sts.in_primary = i_in.func == tcm_pkg::FUNC_PRIMARY;
        o_sts.fill_zero  = fill_s == '0;
        o_sts.lower_ok   = lower_ok;
        o_sts.in_window  = lower_ok && upper_ok;
        o_sts.scan_end   = r_k == fill_s;
        o_sts.found_a    = r_found_a;
        o_sts.out_free   = out_free;
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb <= tcm_pkg::WINDOW_BEFORE_RST;
            r_wa <= tcm_pkg::WINDOW_AFTER_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                tcm_pkg::CFG_WINDOW_BEFORE: r_wb <= i_cfg_data;
                tcm_pkg::CFG_WINDOW_AFTER:  r_wa <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // counters, ring pointers, search offset, match flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_p   <= '0;
            r_cnt[0]  <= '0;
            r_cnt[1]  <= '0;
            r_head[0] <= '0;
            r_head[1] <= '0;
            r_fill[0] <= '0;
            r_fill[1] <= '0;
            r_k       <= '0;
            r_found_a <= 1'b0;
        end else begin
            if (i_cmd.accept && i_in.func == tcm_pkg::FUNC_PRIMARY) begin
                r_cnt_p <= r_cnt_p + 1'b1;
            end
            if (push_en) begin
                r_cnt[push_ring] <= r_cnt[push_ring] + 1'b1;
                if (push_full) begin
                    r_head[push_ring] <= r_head[push_ring] + 1'b1;
                end else begin
                    r_fill[push_ring] <= r_fill[push_ring] + 1'b1;
                end
            end
            if (i_cmd.pop) begin
                r_head[i_cmd.sel] <= head_s + 1'b1;
                r_fill[i_cmd.sel] <= fill_s - 1'b1;
            end
            if (i_cmd.accept || i_cmd.scan_clr) begin
                r_k <= '0;
            end else if (i_cmd.scan_inc) begin
                r_k <= r_k + 1'b1;
            end
            if (i_cmd.take && i_cmd.sel == tcm_pkg::RING_A) begin
                r_found_a <= 1'b1;
            end else if (i_cmd.miss && i_cmd.sel == tcm_pkg::RING_A) begin
                r_found_a <= 1'b0;
            end
        end
    end

    // ring storage and payload latches
    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_time[push_ring][wr_pos] <= i_in.stamp;
            r_val[push_ring][wr_pos]  <= i_in.check_value;
            r_idx[push_ring][wr_pos]  <= r_cnt[push_ring];
        end
        if (i_cmd.accept) begin
            r_p_stamp <= i_in.stamp;
            r_p_val   <= i_in.check_value;
            r_p_idx   <= r_cnt_p;
        end
        if (i_cmd.take) begin
            r_m_time[i_cmd.sel] <= rd_time;
            r_m_val[i_cmd.sel]  <= r_val[i_cmd.sel][rd_pos];
            r_m_idx[i_cmd.sel]  <= r_idx[i_cmd.sel][rd_pos];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.primary_index <= r_p_idx;
            r_out.index_a       <= r_m_idx[0];
            r_out.index_b       <= r_m_idx[1];
            r_out.stamp_primary <= r_p_stamp;
            r_out.stamp_a       <= r_m_time[0];
            r_out.stamp_b       <= r_m_time[1];
            r_out.value_primary <= r_p_val;
            r_out.value_a       <= r_m_val[0];
            r_out.value_b       <= r_m_val[1];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

### rtl/tcm_controller.sv
module tcm_controller (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  tcm_pkg::t_sts   i_sts,
    output tcm_pkg::t_cmd   o_cmd
);

    tcm_pkg::t_state r_state;
    tcm_pkg::t_state n_state;
    logic            r_sel;
    logic            n_sel;
    logic            ring_done;

    // walk over the selected ring ends on a match or past the newest entry
    assign ring_done = i_sts.scan_end || i_sts.in_window;

    // next state
    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        unique case (r_state)
            tcm_pkg::ST_IDLE: begin
                if (i_in_valid && i_sts.in_primary) begin
                    n_state = tcm_pkg::ST_PRUNE;
                    n_sel   = tcm_pkg::RING_A;
                end
            end
            tcm_pkg::ST_PRUNE: begin
                if (i_sts.fill_zero || i_sts.lower_ok) begin
                    n_state = tcm_pkg::ST_FIND;
                end
            end
            tcm_pkg::ST_FIND: begin
                if (ring_done) begin
                    if (r_sel == tcm_pkg::RING_A) begin
                        n_state = tcm_pkg::ST_PRUNE;
                        n_sel   = tcm_pkg::RING_B;
                    end else if (i_sts.found_a && !i_sts.scan_end) begin
                        n_state = tcm_pkg::ST_EMIT;
                    end else begin
                        n_state = tcm_pkg::ST_IDLE;
                    end
                end
            end
            tcm_pkg::ST_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = tcm_pkg::ST_IDLE;
                end
            end
            default: n_state = tcm_pkg::ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_cmd.sel  = r_sel;
        o_in_ready = 1'b0;
        unique case (r_state)
            tcm_pkg::ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            tcm_pkg::ST_PRUNE: begin
                o_cmd.pop = !(i_sts.fill_zero || i_sts.lower_ok);
            end
            tcm_pkg::ST_FIND: begin
                if (i_sts.scan_end) begin
                    o_cmd.miss     = 1'b1;
                    o_cmd.scan_clr = 1'b1;
                end else if (i_sts.in_window) begin
                    o_cmd.take     = 1'b1;
                    o_cmd.scan_clr = 1'b1;
                end else begin
                    o_cmd.scan_inc = 1'b1;
                end
            end
            tcm_pkg::ST_EMIT: begin
                o_cmd.emit = i_sts.out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcm_pkg::ST_IDLE;
            r_sel   <= tcm_pkg::RING_A;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

endmodule

### rtl/timestamp_coincidence_matcher.sv
// Timestamp coincidence matcher.
// Input channel (i_in_valid / o_in_ready / i_in) takes one event request per
// handshake: a primary or a secondary A/B event with stamp and check value.
// Output channel (o_out_valid / i_out_ready / o_out) gives one result request
// per primary event that finds a partner in both secondary rings.
// Window registers are written through i_cfg_we / i_cfg_addr / i_cfg_data.
// Secondary events are taken in the idle state and may arrive back to back.
// A primary event walks ring A and then ring B, one entry per cycle: per ring
// it drops oldest entries while they fall below the window, then searches
// from the oldest remaining entry for the first one inside the window.
// No request is taken until the walk ends; a match adds a load step, and the
// result appears on o_out the cycle after that load.
// The result register decouples the sides: new requests are taken while a
// result waits. If a second match completes before the first is taken, the
// block holds in its load step with o_in_ready low until i_out_ready.
// Synchronous reset empties both rings, clears the sequence counters,
// restores both windows to 200 ticks and drops any pending result.
module timestamp_coincidence_matcher (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  tcm_pkg::t_in                      i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output tcm_pkg::t_out                     o_out,
    input  logic                              i_cfg_we,
    input  logic [tcm_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [tcm_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    tcm_pkg::t_cmd cmd;
    tcm_pkg::t_sts sts;

    tcm_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tcm_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

### rtl/tcm_checker.sv
module tcm_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            o_in_ready,
    input  logic            o_out_valid,
    input  logic            i_out_ready,
    input  tcm_pkg::t_out   o_out
);

    // reset drops any pending result
    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // block is ready for requests straight after reset
    a_rst_ready: assert property (@(posedge i_clk) !i_rst_n |=> o_in_ready)
        else $error("not ready after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed");

    // a new result is loaded only from the load step, where input is blocked
    a_load_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result loaded while taking requests");

    // an accepted request never yields a result in the very next cycle
    a_no_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !o_out_valid |=> !o_out_valid)
        else $error("result too early");

endmodule

bind timestamp_coincidence_matcher tcm_checker u_tcm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

### tb/timestamp_coincidence_matcher_tb.sv
`timescale 1ns / 1ps

module timestamp_coincidence_matcher_tb;

    localparam int             LIMIT_CYCLES  = 400000;
    localparam int             SETTLE_CYCLES = 64;     // longest primary walk plus load, with margin
    localparam int             IDLE_PCT      = 29;
    localparam int             HOLD_CYCLES   = 400;    // receiver hold-off to back up the block
    localparam int             HOLD_AFTER    = 8;      // results seen before the hold-off starts
    localparam tcm_pkg::t_func FUNC_UNUSED   = 2'd3;

    typedef enum logic [1:0] {
        ROW_MODEL,   // expectation from the predictor
        ROW_NONE,    // typed: no result
        ROW_HIT      // typed: the result given in the row
    } t_row_kind;

    typedef struct {
        t_row_kind     kind;
        tcm_pkg::t_in  ev;
        tcm_pkg::t_out want;
    } t_plan_row;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           in_valid;
    logic                           in_ready;
    tcm_pkg::t_in                   in_item;
    logic                           out_valid;
    logic                           out_ready;
    tcm_pkg::t_out                  out_item;
    logic                           cfg_we;
    logic [tcm_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [tcm_pkg::CFG_DATA_W-1:0] cfg_data;

    // predictor state
    logic [tcm_pkg::WIN_W-1:0]  win_before;
    logic [tcm_pkg::WIN_W-1:0]  win_after;
    logic [tcm_pkg::IDX_W-1:0]  primary_count;
    logic [tcm_pkg::IDX_W-1:0]  sec_count [2];
    logic [tcm_pkg::TIME_W-1:0] ring_stamp [2][tcm_pkg::DEPTH];
    logic [tcm_pkg::VAL_W-1:0]  ring_value [2][tcm_pkg::DEPTH];
    logic [tcm_pkg::IDX_W-1:0]  ring_seq [2][tcm_pkg::DEPTH];
    int                         ring_head [2];
    int                         ring_fill [2];

    tcm_pkg::t_out              pending_matches [$];
    t_plan_row                  plan [$];
    logic [tcm_pkg::TIME_W-1:0] sim_now;
    bit                         steady;
    int                         fail_count;
    int                         cycle_count;
    int                         results_seen;
    int                         hold_left;
    logic [tcm_pkg::WIN_W-1:0]  rand_before;
    logic [tcm_pkg::WIN_W-1:0]  rand_after;

    timestamp_coincidence_matcher DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // strictly later than p - before, bound open below zero
    function automatic bit past_floor(logic [tcm_pkg::TIME_W-1:0] t,
                                      logic [tcm_pkg::TIME_W-1:0] p);
        return (t > p) || ((p - t) < tcm_pkg::TIME_W'(win_before));
    endfunction

    // strictly earlier than p + after, bound open past the top
    function automatic bit short_of_ceiling(logic [tcm_pkg::TIME_W-1:0] t,
                                            logic [tcm_pkg::TIME_W-1:0] p);
        return (t < p) || ((t - p) < tcm_pkg::TIME_W'(win_after));
    endfunction

    function automatic void ring_store(logic r, tcm_pkg::t_in ev);
        int pos;
        if (ring_fill[r] == tcm_pkg::DEPTH) begin
            ring_head[r] = (ring_head[r] + 1) % tcm_pkg::DEPTH;
            ring_fill[r] = tcm_pkg::DEPTH - 1;
        end
        pos = (ring_head[r] + ring_fill[r]) % tcm_pkg::DEPTH;
        ring_stamp[r][pos] = ev.stamp;
        ring_value[r][pos] = ev.check_value;
        ring_seq[r][pos]   = sec_count[r];
        ring_fill[r]++;
        sec_count[r] = sec_count[r] + 1'b1;
    endfunction

    function automatic void ring_prune(logic r, logic [tcm_pkg::TIME_W-1:0] p);
        while (ring_fill[r] > 0 && !past_floor(ring_stamp[r][ring_head[r]], p)) begin
            ring_head[r] = (ring_head[r] + 1) % tcm_pkg::DEPTH;
            ring_fill[r]--;
        end
    endfunction

    // oldest entry inside the open window, or -1
    function automatic int ring_search(logic r, logic [tcm_pkg::TIME_W-1:0] p);
        int pos;
        for (int k = 0; k < ring_fill[r]; k++) begin
            pos = (ring_head[r] + k) % tcm_pkg::DEPTH;
            if (past_floor(ring_stamp[r][pos], p) && short_of_ceiling(ring_stamp[r][pos], p))
                return pos;
        end
        return -1;
    endfunction

    function automatic bit predict_coincidence(input tcm_pkg::t_in ev,
                                               output tcm_pkg::t_out res);
        int pa;
        int pb;
        logic [tcm_pkg::IDX_W-1:0] pidx;
        res = '0;
        case (ev.func)
            tcm_pkg::FUNC_SEC_A: begin
                ring_store(tcm_pkg::RING_A, ev);
                return 1'b0;
            end
            tcm_pkg::FUNC_SEC_B: begin
                ring_store(tcm_pkg::RING_B, ev);
                return 1'b0;
            end
            tcm_pkg::FUNC_PRIMARY: begin
                pidx = primary_count;
                primary_count = primary_count + 1'b1;
                ring_prune(tcm_pkg::RING_A, ev.stamp);
                ring_prune(tcm_pkg::RING_B, ev.stamp);
                pa = ring_search(tcm_pkg::RING_A, ev.stamp);
                pb = ring_search(tcm_pkg::RING_B, ev.stamp);
                if (pa < 0 || pb < 0)
                    return 1'b0;
                res.primary_index = pidx;
                res.index_a       = ring_seq[tcm_pkg::RING_A][pa];
                res.index_b       = ring_seq[tcm_pkg::RING_B][pb];
                res.stamp_primary = ev.stamp;
                res.stamp_a       = ring_stamp[tcm_pkg::RING_A][pa];
                res.stamp_b       = ring_stamp[tcm_pkg::RING_B][pb];
                res.value_primary = ev.check_value;
                res.value_a       = ring_value[tcm_pkg::RING_A][pa];
                res.value_b       = ring_value[tcm_pkg::RING_B][pb];
                return 1'b1;
            end
            default: return 1'b0;   // unused source code
        endcase
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    function automatic tcm_pkg::t_out res_of(logic [tcm_pkg::IDX_W-1:0] pi,
                                             logic [tcm_pkg::IDX_W-1:0] ia,
                                             logic [tcm_pkg::IDX_W-1:0] ib,
                                             logic [tcm_pkg::TIME_W-1:0] sp,
                                             logic [tcm_pkg::TIME_W-1:0] sa,
                                             logic [tcm_pkg::TIME_W-1:0] sb,
                                             logic [tcm_pkg::VAL_W-1:0] vp,
                                             logic [tcm_pkg::VAL_W-1:0] va,
                                             logic [tcm_pkg::VAL_W-1:0] vb);
        tcm_pkg::t_out r;
        r.primary_index = pi;
        r.index_a       = ia;
        r.index_b       = ib;
        r.stamp_primary = sp;
        r.stamp_a       = sa;
        r.stamp_b       = sb;
        r.value_primary = vp;
        r.value_a       = va;
        r.value_b       = vb;
        return r;
    endfunction

    function automatic t_plan_row row(t_row_kind k, tcm_pkg::t_func f,
                                      logic [tcm_pkg::TIME_W-1:0] s,
                                      logic [tcm_pkg::VAL_W-1:0] v,
                                      tcm_pkg::t_out want = '0);
        t_plan_row pr;
        pr.kind           = k;
        pr.ev.func        = f;
        pr.ev.stamp       = s;
        pr.ev.check_value = v;
        pr.want           = want;
        return pr;
    endfunction

    // next event of a random stream around a shared time base
    function automatic tcm_pkg::t_in next_random_event(int unsigned step,
                                                       int unsigned prim_pct);
        tcm_pkg::t_in ev;
        int unsigned pick;
        logic [tcm_pkg::TIME_W-1:0] back;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            ev.func = FUNC_UNUSED;
        else if (pick < 4 + prim_pct)
            ev.func = tcm_pkg::FUNC_PRIMARY;
        else if ($urandom_range(0, 1) == 0)
            ev.func = tcm_pkg::FUNC_SEC_A;
        else
            ev.func = tcm_pkg::FUNC_SEC_B;
        // occasional long jump so that whole rings get pruned
        if ($urandom_range(0, 49) == 0)
            sim_now = sim_now + tcm_pkg::TIME_W'($urandom_range(0, 1000000));
        else
            sim_now = sim_now + tcm_pkg::TIME_W'($urandom_range(0, step));
        ev.stamp = sim_now;
        // a few stamps out of order
        if ($urandom_range(0, 19) == 0) begin
            back = tcm_pkg::TIME_W'($urandom_range(0, 4 * step));
            ev.stamp = (sim_now > back) ? sim_now - back : '0;
        end
        ev.check_value = tcm_pkg::VAL_W'($urandom_range(0, 65535));
        return ev;
    endfunction

    // offer one event request; predict on acceptance; returns at the next falling edge
    task automatic send_event(input tcm_pkg::t_in ev, input t_row_kind kind,
                              input tcm_pkg::t_out want);
        tcm_pkg::t_out res;
        bit hit;
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid = 1'b0;
            @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_item  = ev;
        do
            @(posedge i_clk);
        while (!in_ready);
        hit = predict_coincidence(ev, res);
        case (kind)
            ROW_MODEL: if (hit) pending_matches.push_back(res);
            ROW_HIT:   pending_matches.push_back(want);
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic write_window(input logic [tcm_pkg::CFG_ADDR_W-1:0] addr,
                                input logic [tcm_pkg::CFG_DATA_W-1:0] data);
        cfg_we   = 1'b1;
        cfg_addr = addr;
        cfg_data = data;
        @(negedge i_clk);
        cfg_we = 1'b0;
        if (addr == tcm_pkg::CFG_WINDOW_BEFORE)
            win_before = data;
        else
            win_after = data;
    endtask

    // all results in, then let any unmatched primary finish its walk
    task automatic drain;
        in_valid = 1'b0;
        while (pending_matches.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic run_phase(input logic [tcm_pkg::WIN_W-1:0] wb,
                             input logic [tcm_pkg::WIN_W-1:0] wa,
                             input int unsigned step, input int unsigned prim_pct,
                             input logic [tcm_pkg::TIME_W-1:0] start, input int count,
                             input bit calm);
        tcm_pkg::t_in ev;
        int n;
        drain();
        write_window(tcm_pkg::CFG_WINDOW_BEFORE, wb);
        write_window(tcm_pkg::CFG_WINDOW_AFTER, wa);
        sim_now = start;
        steady  = calm;
        n = 0;
        while (n < count) begin
            ev = next_random_event(step, prim_pct);
            if (ev.func != FUNC_UNUSED)
                n++;
            send_event(ev, ROW_MODEL, '0);
        end
        in_valid = 1'b0;
        steady   = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    // ---------------------------------------------------------------
    // result side: random stalls, one long hold-off, checking
    // ---------------------------------------------------------------
    initial begin
        tcm_pkg::t_out want;
        out_ready    = 1'b0;
        results_seen = 0;
        hold_left    = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                out_ready = 1'b0;
                hold_left--;
            end else if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
                out_ready = 1'b0;
            end else begin
                out_ready = 1'b1;
            end
            @(posedge i_clk);
            if (out_valid === 1'b1 && out_ready) begin
                if (pending_matches.size() == 0) begin
                    $error("unexpected match result, primary_index %0h",
                           out_item.primary_index);
                    fail_count++;
                end else begin
                    want = pending_matches.pop_front();
                    check_field("primary_index", 64'(want.primary_index),
                                64'(out_item.primary_index));
                    check_field("index_a", 64'(want.index_a), 64'(out_item.index_a));
                    check_field("index_b", 64'(want.index_b), 64'(out_item.index_b));
                    check_field("stamp_primary", 64'(want.stamp_primary),
                                64'(out_item.stamp_primary));
                    check_field("stamp_a", 64'(want.stamp_a), 64'(out_item.stamp_a));
                    check_field("stamp_b", 64'(want.stamp_b), 64'(out_item.stamp_b));
                    check_field("value_primary", 64'(want.value_primary),
                                64'(out_item.value_primary));
                    check_field("value_a", 64'(want.value_a), 64'(out_item.value_a));
                    check_field("value_b", 64'(want.value_b), 64'(out_item.value_b));
                end
                results_seen++;
                if (results_seen == HOLD_AFTER)
                    hold_left = HOLD_CYCLES;
            end
        end
    end

    // watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial begin
        i_rst_n    = 1'b0;
        in_valid   = 1'b0;
        in_item    = '0;
        cfg_we     = 1'b0;
        cfg_addr   = tcm_pkg::CFG_WINDOW_BEFORE;
        cfg_data   = '0;
        steady     = 1'b0;
        fail_count = 0;
        sim_now    = '0;

        win_before    = tcm_pkg::WINDOW_BEFORE_RST;
        win_after     = tcm_pkg::WINDOW_AFTER_RST;
        primary_count = '0;
        sec_count[0]  = '0;
        sec_count[1]  = '0;
        ring_head[0]  = 0;
        ring_head[1]  = 0;
        ring_fill[0]  = 0;
        ring_fill[1]  = 0;

        // directed events, reset windows of 200 ticks
        // primary at zero with empty rings: lower bound open, nothing to match
        plan.push_back(row(ROW_NONE, tcm_pkg::FUNC_PRIMARY, 48'h0, 16'h0000));
        // unused source code with every bit set: ignored
        plan.push_back(row(ROW_NONE, FUNC_UNUSED, 48'hFFFF_FFFF_FFFF, 16'hFFFF));
        plan.push_back(row(ROW_MODEL, tcm_pkg::FUNC_SEC_A, 48'h0, 16'h0000));
        plan.push_back(row(ROW_MODEL, tcm_pkg::FUNC_SEC_B, 48'h0, 16'hFFFF));
        plan.push_back(row(ROW_HIT, tcm_pkg::FUNC_PRIMARY, 48'h0, 16'h1234,
                           res_of(1, 0, 0, 48'h0, 48'h0, 48'h0, 16'h1234, 16'h0000, 16'hFFFF)));
        // prune at exactly p - before, match just under p + after
        plan.push_back(row(ROW_MODEL, tcm_pkg::FUNC_SEC_A, 48'd150, 16'h00A5));
        plan.push_back(row(ROW_MODEL, tcm_pkg::FUNC_SEC_B, 48'd399, 16'h5A00));
        plan.push_back(row(ROW_HIT, tcm_pkg::FUNC_PRIMARY, 48'd200, 16'hBEEF,
                           res_of(2, 1, 1, 48'd200, 48'd150, 48'd399,
                                  16'hBEEF, 16'h00A5, 16'h5A00)));
        plan.push_back(row(ROW_MODEL, tcm_pkg::FUNC_SEC_B, 48'd400, 16'h0F0F));
        // ring A pruned empty: no result
        plan.push_back(row(ROW_NONE, tcm_pkg::FUNC_PRIMARY, 48'd350, 16'h4444));
        // top of the time range: upper bound open
        plan.push_back(row(ROW_MODEL, tcm_pkg::FUNC_SEC_A, 48'hFFFF_FFFF_FFF5, 16'h8001));
        plan.push_back(row(ROW_MODEL, tcm_pkg::FUNC_SEC_B, 48'hFFFF_FFFF_FFFF, 16'h7FFE));
        plan.push_back(row(ROW_HIT, tcm_pkg::FUNC_PRIMARY, 48'hFFFF_FFFF_FFFA, 16'hC3C3,
                           res_of(4, 2, 3, 48'hFFFF_FFFF_FFFA, 48'hFFFF_FFFF_FFF5,
                                  48'hFFFF_FFFF_FFFF, 16'hC3C3, 16'h8001, 16'h7FFE)));
        // out-of-order stamp behind a newer one in ring A
        plan.push_back(row(ROW_MODEL, tcm_pkg::FUNC_SEC_A, 48'd100, 16'h0001));
        plan.push_back(row(ROW_MODEL, tcm_pkg::FUNC_PRIMARY, 48'hFFFF_FFFF_FFFF, 16'hA5A5));
        plan.push_back(row(ROW_MODEL, tcm_pkg::FUNC_PRIMARY, 48'd150, 16'h5A5A));

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (plan[i])
            send_event(plan[i].ev, plan[i].kind, plan[i].want);

        // random phases over several window settings
        run_phase(16'd200, 16'd200, 60, 25, tcm_pkg::TIME_W'({$urandom, $urandom}), 190, 1'b0);
        run_phase(16'd0, 16'd0, 20, 25, tcm_pkg::TIME_W'({$urandom, $urandom}), 50, 1'b0);
        run_phase(16'hFFFF, 16'hFFFF, 8000, 20, tcm_pkg::TIME_W'({$urandom, $urandom}),
                  100, 1'b1);
        run_phase(16'd0, 16'hFFFF, 8000, 25, tcm_pkg::TIME_W'({$urandom, $urandom}), 50, 1'b0);
        run_phase(16'hFFFF, 16'd0, 8000, 25, tcm_pkg::TIME_W'({$urandom, $urandom}), 50, 1'b0);
        // few primaries: rings run full and drop their oldest entries
        run_phase(16'd300, 16'd50, 40, 5, tcm_pkg::TIME_W'({$urandom, $urandom}), 60, 1'b0);
        rand_before = tcm_pkg::WIN_W'($urandom_range(0, 65535));
        rand_after  = tcm_pkg::WIN_W'($urandom_range(0, 65535));
        run_phase(rand_before, rand_after, (rand_before + rand_after) / 8 + 1, 25,
                  48'hFFFF_FFFF_FFFF - tcm_pkg::TIME_W'($urandom_range(0, 20000)), 80, 1'b0);
        run_phase(16'd200, 16'd200, 60, 25, 48'h0, 50, 1'b0);

        drain();
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### sim.f
rtl/tcm_pkg.sv
rtl/tcm_datapath.sv
rtl/tcm_controller.sv
rtl/timestamp_coincidence_matcher.sv
rtl/tcm_checker.sv
tb/timestamp_coincidence_matcher_tb.sv
